>>> rtl/wsdf_pkg.sv
// wsdf_pkg: types and constants shared by the websocket frame deframer
// no dependencies

package wsdf_pkg;

  typedef enum logic [6:0] {
    PH_HDR0   = 7'b0000001,
    PH_HDR1   = 7'b0000010,
    PH_EXT_HI = 7'b0000100,
    PH_EXT_LO = 7'b0001000,
    PH_KEY    = 7'b0010000,
    PH_DATA   = 7'b0100000,
    PH_SKIP   = 7'b1000000
  } phase_t;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_BYTE  = 2'd0;
  localparam kind_t KIND_EMPTY = 2'd1;
  localparam kind_t KIND_TRUNC = 2'd2;
  localparam kind_t KIND_UNSUP = 2'd3;

  localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
  localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

endpackage

>>> rtl/wsdf_in_if.sv
// wsdf_in_if: received byte channel (valid/ready plus byte and buffer end mark)
// depends on nothing

interface wsdf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       buffer_end;

  modport source (output valid, output data_byte, output buffer_end, input ready);
  modport sink   (input valid, input data_byte, input buffer_end, output ready);
endinterface

>>> rtl/wsdf_out_if.sv
// wsdf_out_if: result channel of the deframer (payload bytes and frame events)
// uses wsdf_pkg for the kind type

interface wsdf_out_if;
  logic                valid;
  logic                ready;
  wsdf_pkg::kind_t     kind;
  logic [7:0]          payload_byte;
  logic                last_of_frame;
  logic                fin_flag;
  logic [3:0]          frame_opcode;
  logic                was_masked;
  logic [15:0]         payload_length;

  modport source (output valid, output kind, output payload_byte, output last_of_frame,
                  output fin_flag, output frame_opcode, output was_masked,
                  output payload_length, input ready);
  modport sink   (input valid, input kind, input payload_byte, input last_of_frame,
                  input fin_flag, input frame_opcode, input was_masked,
                  input payload_length, output ready);
endinterface

>>> rtl/websocket_frame_deframer_top.sv
// Websocket frame deframer: takes one received byte per clock and parses one frame
// per read buffer (FIN, opcode, mask bit, 7-bit or 16-bit length, optional mask key),
// then returns the unmasked payload bytes, the last one flagged. A buffer that ends
// early gives a truncated event, a 64-bit length code an unsupported event, a zero
// length frame an empty-frame event; header bytes and trailing bytes give nothing.
// One byte is taken every cycle while results are being taken; a byte that yields a
// result passes through the input register and then the result register before it is
// presented on the output. A result left waiting holds the input register, which then
// stalls the input. The parser state is updated combinationally between the two
// registers, which sets the one-byte-per-cycle rate.
// Depends on wsdf_pkg, wsdf_in_if and wsdf_out_if.

module websocket_frame_deframer_top (
  input  logic        clk,
  input  logic        rst_n,
  wsdf_in_if.sink     in_bus,
  wsdf_out_if.source  out_bus
);

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_end_r;

  // parser state
  wsdf_pkg::phase_t ph_r, ph_nxt;
  logic        fin_r, fin_nxt;
  logic [3:0]  op_r, op_nxt;
  logic        mask_r, mask_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [7:0]  key_r [4];

  // result register
  logic             out_valid_r;
  wsdf_pkg::kind_t  out_kind_r;
  logic [7:0]       out_byte_r;
  logic             out_last_r;
  logic             out_fin_r;
  logic [3:0]       out_op_r;
  logic             out_mask_r;
  logic [15:0]      out_len_r;

  logic             res_fire;
  wsdf_pkg::kind_t  res_kind;
  logic [7:0]       res_byte;
  logic             res_last;
  logic             len_known;
  logic             hdr_done;
  logic             key_we;
  logic [1:0]       pos;
  logic [15:0]      cnt_inc;

  logic s2_free;
  logic go;

  assign s2_free      = !out_valid_r || out_bus.ready;
  assign go           = s1_valid_r && s2_free;
  assign in_bus.ready = !s1_valid_r || s2_free;

  assign pos     = cnt_r[1:0];
  assign cnt_inc = cnt_r + 16'd1;

  always_comb begin
    ph_nxt    = ph_r;
    fin_nxt   = fin_r;
    op_nxt    = op_r;
    mask_nxt  = mask_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    res_fire  = 1'b0;
    res_kind  = wsdf_pkg::KIND_BYTE;
    res_byte  = 8'd0;
    res_last  = 1'b0;
    len_known = 1'b0;
    hdr_done  = 1'b0;
    key_we    = 1'b0;
    if (go) begin
      case (ph_r)
        wsdf_pkg::PH_HDR1: begin
          mask_nxt = s1_byte_r[7];
          if (s1_byte_r[6:0] == wsdf_pkg::LEN_CODE_EXT64) begin
            len_nxt  = 16'd0;
            ph_nxt   = s1_end_r ? wsdf_pkg::PH_HDR0 : wsdf_pkg::PH_SKIP;
            res_fire = 1'b1;
            res_kind = wsdf_pkg::KIND_UNSUP;
          end else if (s1_byte_r[6:0] == wsdf_pkg::LEN_CODE_EXT16) begin
            len_nxt = 16'd0;
            if (s1_end_r) begin
              ph_nxt   = wsdf_pkg::PH_HDR0;
              res_fire = 1'b1;
              res_kind = wsdf_pkg::KIND_TRUNC;
            end else begin
              ph_nxt = wsdf_pkg::PH_EXT_HI;
            end
          end else begin
            len_nxt   = {9'd0, s1_byte_r[6:0]};
            len_known = 1'b1;
          end
        end
        wsdf_pkg::PH_EXT_HI: begin
          len_nxt = {s1_byte_r, 8'd0};
          if (s1_end_r) begin
            ph_nxt   = wsdf_pkg::PH_HDR0;
            res_fire = 1'b1;
            res_kind = wsdf_pkg::KIND_TRUNC;
          end else begin
            ph_nxt = wsdf_pkg::PH_EXT_LO;
          end
        end
        wsdf_pkg::PH_EXT_LO: begin
          len_nxt   = {len_r[15:8], s1_byte_r};
          len_known = 1'b1;
        end
        wsdf_pkg::PH_KEY: begin
          key_we = 1'b1;
          if (pos == 2'd3) begin
            hdr_done = 1'b1;
          end else begin
            cnt_nxt = {14'd0, pos + 2'd1};
            if (s1_end_r) begin
              ph_nxt   = wsdf_pkg::PH_HDR0;
              res_fire = 1'b1;
              res_kind = wsdf_pkg::KIND_TRUNC;
            end
          end
        end
        wsdf_pkg::PH_DATA: begin
          cnt_nxt = cnt_inc;
          if (cnt_inc == len_r) begin
            ph_nxt   = s1_end_r ? wsdf_pkg::PH_HDR0 : wsdf_pkg::PH_SKIP;
            res_fire = 1'b1;
            res_byte = s1_byte_r ^ (mask_r ? key_r[pos] : 8'd0);
            res_last = 1'b1;
          end else if (s1_end_r) begin
            ph_nxt   = wsdf_pkg::PH_HDR0;
            res_fire = 1'b1;
            res_kind = wsdf_pkg::KIND_TRUNC;
          end else begin
            res_fire = 1'b1;
            res_byte = s1_byte_r ^ (mask_r ? key_r[pos] : 8'd0);
          end
        end
        wsdf_pkg::PH_SKIP: begin
          if (s1_end_r) begin
            ph_nxt = wsdf_pkg::PH_HDR0;
          end
        end
        default: begin
          // first header byte, also recovers from any stray phase code
          fin_nxt  = s1_byte_r[7];
          op_nxt   = s1_byte_r[3:0];
          mask_nxt = 1'b0;
          len_nxt  = 16'd0;
          cnt_nxt  = 16'd0;
          if (s1_end_r) begin
            ph_nxt   = wsdf_pkg::PH_HDR0;
            res_fire = 1'b1;
            res_kind = wsdf_pkg::KIND_TRUNC;
          end else begin
            ph_nxt = wsdf_pkg::PH_HDR1;
          end
        end
      endcase

      // length complete: masked frames still need the key
      if (len_known) begin
        if (mask_nxt) begin
          cnt_nxt = 16'd0;
          if (s1_end_r) begin
            ph_nxt   = wsdf_pkg::PH_HDR0;
            res_fire = 1'b1;
            res_kind = wsdf_pkg::KIND_TRUNC;
          end else begin
            ph_nxt = wsdf_pkg::PH_KEY;
          end
        end else begin
          hdr_done = 1'b1;
        end
      end

      if (hdr_done) begin
        cnt_nxt = 16'd0;
        if (len_nxt == 16'd0) begin
          ph_nxt   = s1_end_r ? wsdf_pkg::PH_HDR0 : wsdf_pkg::PH_SKIP;
          res_fire = 1'b1;
          res_kind = wsdf_pkg::KIND_EMPTY;
        end else if (s1_end_r) begin
          ph_nxt   = wsdf_pkg::PH_HDR0;
          res_fire = 1'b1;
          res_kind = wsdf_pkg::KIND_TRUNC;
        end else begin
          ph_nxt = wsdf_pkg::PH_DATA;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      s1_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      s1_byte_r <= in_bus.data_byte;
      s1_end_r  <= in_bus.buffer_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= wsdf_pkg::PH_HDR0;
      fin_r  <= 1'b0;
      op_r   <= 4'd0;
      mask_r <= 1'b0;
      len_r  <= 16'd0;
      cnt_r  <= 16'd0;
    end else begin
      ph_r   <= ph_nxt;
      fin_r  <= fin_nxt;
      op_r   <= op_nxt;
      mask_r <= mask_nxt;
      len_r  <= len_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // key bytes are always all written before any masked payload byte reads them
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_r[pos] <= s1_byte_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_free) begin
      out_valid_r <= res_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (go && res_fire) begin
      out_kind_r <= res_kind;
      out_byte_r <= res_byte;
      out_last_r <= res_last;
      out_fin_r  <= fin_nxt;
      out_op_r   <= op_nxt;
      out_mask_r <= mask_nxt;
      out_len_r  <= len_nxt;
    end
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.kind           = out_kind_r;
  assign out_bus.payload_byte   = out_byte_r;
  assign out_bus.last_of_frame  = out_last_r;
  assign out_bus.fin_flag       = out_fin_r;
  assign out_bus.frame_opcode   = out_op_r;
  assign out_bus.was_masked     = out_mask_r;
  assign out_bus.payload_length = out_len_r;

endmodule

>>> sim/websocket_frame_deframer_top_tb.sv
// testbench for websocket_frame_deframer_top: sends read buffers byte by byte and checks
// every result against a local frame-parser model, with random idling on both channels
// depends on wsdf_pkg, wsdf_in_if, wsdf_out_if and the deframer rtl

module websocket_frame_deframer_top_tb;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_ITEMS = 700;
  localparam int MAX_WAIT     = 12;

  typedef logic [7:0] octet_q_t[$];

  typedef struct packed {
    wsdf_pkg::kind_t kind;
    logic [7:0]      payload_byte;
    logic            last_of_frame;
    logic            fin_flag;
    logic [3:0]      frame_opcode;
    logic            was_masked;
    logic [15:0]     payload_length;
  } deframe_result_t;

  logic clk;
  logic rst_n;

  wsdf_in_if  in_bus ();
  wsdf_out_if out_bus ();

  websocket_frame_deframer_top u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  // parser model state
  wsdf_pkg::phase_t ph;
  logic        fin_q;
  logic [3:0]  opc_q;
  logic        mask_q;
  logic [15:0] len_q;
  logic [31:0] key_q;
  logic [15:0] cnt_q;

  deframe_result_t expected_events[$];

  int  error_count;
  int  results_seen;
  int  kind_count[4];
  int  bytes_sent;
  int  buffers_sent;
  int  cycle_count;
  int  sender_gap;
  bit  quiet;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %h want %h", results_seen, name, got, want));
  endtask

  function automatic void note_event(wsdf_pkg::kind_t k, logic [7:0] v, logic is_final);
    deframe_result_t e;
    e.kind           = k;
    e.payload_byte   = v;
    e.last_of_frame  = is_final;
    e.fin_flag       = fin_q;
    e.frame_opcode   = opc_q;
    e.was_masked     = mask_q;
    e.payload_length = len_q;
    expected_events.push_back(e);
  endfunction

  function automatic void truncate_frame();
    ph = wsdf_pkg::PH_HDR0;
    note_event(wsdf_pkg::KIND_TRUNC, 8'h00, 1'b0);
  endfunction

  // header complete, key included when masked
  function automatic void header_complete(logic is_last);
    cnt_q = '0;
    if (len_q == 16'd0) begin
      ph = is_last ? wsdf_pkg::PH_HDR0 : wsdf_pkg::PH_SKIP;
      note_event(wsdf_pkg::KIND_EMPTY, 8'h00, 1'b0);
    end else if (is_last) begin
      truncate_frame();
    end else begin
      ph = wsdf_pkg::PH_DATA;
    end
  endfunction

  function automatic void length_complete(logic is_last);
    if (mask_q) begin
      cnt_q = '0;
      if (is_last) truncate_frame();
      else ph = wsdf_pkg::PH_KEY;
    end else begin
      header_complete(is_last);
    end
  endfunction

  function automatic void predict_byte(logic [7:0] b, logic is_last);
    logic [6:0] code;
    logic [7:0] v;
    int         pos;
    case (ph)
      wsdf_pkg::PH_HDR1: begin
        code   = b[6:0];
        mask_q = b[7];
        if (code == wsdf_pkg::LEN_CODE_EXT64) begin
          len_q = '0;
          ph = is_last ? wsdf_pkg::PH_HDR0 : wsdf_pkg::PH_SKIP;
          note_event(wsdf_pkg::KIND_UNSUP, 8'h00, 1'b0);
        end else if (code == wsdf_pkg::LEN_CODE_EXT16) begin
          len_q = '0;
          if (is_last) truncate_frame();
          else ph = wsdf_pkg::PH_EXT_HI;
        end else begin
          len_q = {9'd0, code};
          length_complete(is_last);
        end
      end
      wsdf_pkg::PH_EXT_HI: begin
        len_q = {b, 8'h00};
        if (is_last) truncate_frame();
        else ph = wsdf_pkg::PH_EXT_LO;
      end
      wsdf_pkg::PH_EXT_LO: begin
        len_q[7:0] = b;
        length_complete(is_last);
      end
      wsdf_pkg::PH_KEY: begin
        pos = int'(cnt_q[1:0]);
        key_q[(3 - pos) * 8 +: 8] = b;
        if (pos == 3) begin
          header_complete(is_last);
        end else begin
          cnt_q = 16'(pos + 1);
          if (is_last) truncate_frame();
        end
      end
      wsdf_pkg::PH_DATA: begin
        v = b;
        // key byte 0 sits in the top byte of the key register
        if (mask_q) v = v ^ key_q[(3 - int'(cnt_q[1:0])) * 8 +: 8];
        cnt_q = cnt_q + 16'd1;
        if (cnt_q == len_q) begin
          ph = is_last ? wsdf_pkg::PH_HDR0 : wsdf_pkg::PH_SKIP;
          note_event(wsdf_pkg::KIND_BYTE, v, 1'b1);
        end else if (is_last) begin
          truncate_frame();
        end else begin
          note_event(wsdf_pkg::KIND_BYTE, v, 1'b0);
        end
      end
      wsdf_pkg::PH_SKIP: begin
        if (is_last) ph = wsdf_pkg::PH_HDR0;
      end
      default: begin
        fin_q  = b[7];
        opc_q  = b[3:0];
        mask_q = 1'b0;
        len_q  = '0;
        key_q  = '0;
        cnt_q  = '0;
        if (is_last) truncate_frame();
        else ph = wsdf_pkg::PH_HDR1;
      end
    endcase
  endfunction

  // predict on every accepted byte, check every accepted result
  always @(posedge clk) begin : monitor
    deframe_result_t got;
    deframe_result_t want;
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) predict_byte(in_bus.data_byte, in_bus.buffer_end);
      if (out_bus.valid && out_bus.ready) begin
        got.kind           = out_bus.kind;
        got.payload_byte   = out_bus.payload_byte;
        got.last_of_frame  = out_bus.last_of_frame;
        got.fin_flag       = out_bus.fin_flag;
        got.frame_opcode   = out_bus.frame_opcode;
        got.was_masked     = out_bus.was_masked;
        got.payload_length = out_bus.payload_length;
        results_seen++;
        if (expected_events.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          want = expected_events.pop_front();
          check_field("kind", 16'(got.kind), 16'(want.kind));
          check_field("payload_byte", 16'(got.payload_byte), 16'(want.payload_byte));
          check_field("last_of_frame", 16'(got.last_of_frame), 16'(want.last_of_frame));
          check_field("fin_flag", 16'(got.fin_flag), 16'(want.fin_flag));
          check_field("frame_opcode", 16'(got.frame_opcode), 16'(want.frame_opcode));
          check_field("was_masked", 16'(got.was_masked), 16'(want.was_masked));
          check_field("payload_length", got.payload_length, want.payload_length);
          kind_count[want.kind]++;
        end
      end
    end
  end

  function automatic int draw_wait();
    return quiet ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // one byte transaction; valid drops after it only when a gap follows
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    if (sender_gap > 0) repeat (sender_gap) @(posedge clk);
    in_bus.valid      <= 1'b1;
    in_bus.data_byte  <= b;
    in_bus.buffer_end <= is_last;
    do @(posedge clk); while (!in_bus.ready);
    sender_gap = draw_wait();
    if (sender_gap > 0) in_bus.valid <= 1'b0;
  endtask

  task automatic send_buffer(input octet_q_t octets, input int counted);
    for (int i = 0; i < octets.size(); i++) begin
      send_byte(octets[i], i == octets.size() - 1);
      if (i < counted) bytes_sent++;
    end
    buffers_sent++;
  endtask

  // hold the sender until every predicted result has come out
  task automatic drain_results();
    if (sender_gap == 0) in_bus.valid <= 1'b0;
    @(posedge clk);
    while (expected_events.size() != 0) @(posedge clk);
    sender_gap = 0;
  endtask

  function automatic octet_q_t build_frame(logic [7:0] hdr0, logic masked, int len, bit ext16);
    octet_q_t    octets;
    logic [15:0] len16;
    len16 = 16'(len);
    octets.push_back(hdr0);
    if (ext16) begin
      octets.push_back({masked, wsdf_pkg::LEN_CODE_EXT16});
      octets.push_back(len16[15:8]);
      octets.push_back(len16[7:0]);
    end else begin
      octets.push_back({masked, len16[6:0]});
    end
    if (masked) repeat (4) octets.push_back(8'($urandom));
    repeat (len) octets.push_back(8'($urandom));
    return octets;
  endfunction

  task automatic test_short_headers();
    octet_q_t octets;
    octets = {8'h81};
    send_buffer(octets, 1);
    // 16-bit length of all ones, masked, buffer ends right after the length
    octets = {8'h0F, 8'hFE, 8'hFF, 8'hFF};
    send_buffer(octets, 4);
  endtask

  task automatic test_unsupported_length();
    octet_q_t octets;
    octets = {8'h82, 8'hFF, 8'h00, 8'h55};
    send_buffer(octets, 2);
  endtask

  task automatic test_empty_masked_frame();
    octet_q_t octets;
    octets = {8'h89, 8'h80, 8'hDE, 8'hAD, 8'hBE, 8'hEF};
    send_buffer(octets, 6);
  endtask

  task automatic test_masked_payload();
    octet_q_t octets;
    quiet = 1'b1;
    octets = {8'h81, 8'h83, 8'hA5, 8'h5A, 8'hFF, 8'h00, 8'h12, 8'h34, 8'h56, 8'h77};
    send_buffer(octets, 9);
    quiet = 1'b0;
  endtask

  task automatic test_truncated_payload();
    octet_q_t octets;
    octets = {8'h02, 8'h05, 8'h11, 8'h22};
    send_buffer(octets, 4);
  endtask

  task automatic test_random_buffers();
    octet_q_t octets;
    int       sel;
    int       len;
    int       counted;
    int       target;
    target = bytes_sent + RANDOM_ITEMS;
    while (bytes_sent < target) begin
      if ($urandom_range(0, 15) == 0) quiet = !quiet;
      sel = $urandom_range(0, 99);
      len = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 24);
      octets = build_frame(8'($urandom), 1'($urandom), len,
                           (len > 125) || ($urandom_range(0, 7) == 0));
      counted = octets.size();
      if (sel < 65) begin
        repeat ($urandom_range(0, 3)) octets.push_back(8'($urandom));
      end else if (sel < 85) begin
        // cut anywhere inside the frame
        counted = $urandom_range(1, octets.size() - 1);
        while (octets.size() > counted) void'(octets.pop_back());
      end else if (sel < 95) begin
        octets = {8'($urandom)};
        octets.push_back({1'($urandom), wsdf_pkg::LEN_CODE_EXT64});
        counted = 2;
        repeat ($urandom_range(0, 3)) octets.push_back(8'($urandom));
      end else begin
        octets = {8'($urandom)};
        repeat ($urandom_range(0, 5)) octets.push_back(8'($urandom));
        counted = octets.size();
      end
      if ($urandom_range(0, 29) == 0) drain_results();
      send_buffer(octets, counted);
    end
  endtask

  // ready side: a fresh stall is drawn for each result transaction
  initial begin : result_sink
    int stall;
    out_bus.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still pending",
             cycle_count, expected_events.size());
    $display("websocket_frame_deframer_top_tb NOT OK");
    $finish;
  end

  initial begin : stimulus
    ph           = wsdf_pkg::PH_HDR0;
    fin_q        = 1'b0;
    opc_q        = '0;
    mask_q       = 1'b0;
    len_q        = '0;
    key_q        = '0;
    cnt_q        = '0;
    error_count  = 0;
    results_seen = 0;
    bytes_sent   = 0;
    buffers_sent = 0;
    sender_gap   = 0;
    quiet        = 1'b0;
    for (int k = 0; k < 4; k++) kind_count[k] = 0;

    rst_n             <= 1'b0;
    in_bus.valid      <= 1'b0;
    in_bus.data_byte  <= 8'h00;
    in_bus.buffer_end <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_short_headers();
    test_unsupported_length();
    test_empty_masked_frame();
    drain_results();
    test_masked_payload();
    test_truncated_payload();
    test_random_buffers();

    drain_results();
    repeat (8) @(posedge clk);

    $display("sent %0d buffers (%0d frame bytes); checked %0d payload bytes, %0d empty,",
             buffers_sent, bytes_sent, kind_count[wsdf_pkg::KIND_BYTE],
             kind_count[wsdf_pkg::KIND_EMPTY]);
    $display("%0d truncated and %0d unsupported-length results, %0d mismatches",
             kind_count[wsdf_pkg::KIND_TRUNC], kind_count[wsdf_pkg::KIND_UNSUP], error_count);
    if (error_count == 0) begin
      $display("websocket_frame_deframer_top_tb OK");
    end else begin
      $display("websocket_frame_deframer_top_tb NOT OK");
    end
    $finish;
  end

endmodule
